@@ rtl/core/sxfb_pkg.sv @@
// ----------------------------------------------------------------------------
// sxfb_pkg
// Shared types for the sprite XOR framebuffer: request and result payloads,
// operation codes, controller states and the row store control group.
// ----------------------------------------------------------------------------
package sxfb_pkg;

    // Widths fixed by the request and result formats
    localparam int unsigned OP_W       = 2;
    localparam int unsigned XPOS_W     = 6;
    localparam int unsigned YPOS_W     = 5;
    localparam int unsigned OFFSET_W   = 4;
    localparam int unsigned SPRITE_W   = 8;
    localparam int unsigned PIXELS_W   = 64;
    // origin row (below 32) plus row offset (below 16) fits in six bits
    localparam int unsigned ROW_SUM_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [XPOS_W-1:0]   x_pos;
        logic [YPOS_W-1:0]   y_pos;
        logic [OFFSET_W-1:0] row_offset;
        logic [SPRITE_W-1:0] sprite_row;
        logic                last_row;
    } req_t;

    typedef struct packed {
        logic                collision;
        logic                sprite_done;
        logic [PIXELS_W-1:0] row_pixels;
    } rsp_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } store_ctrl_t;

endpackage

@@ rtl/core/sxfb_row_store.sv @@
// ----------------------------------------------------------------------------
// sxfb_row_store
// Framebuffer row memory, one word per pixel row, with a registered read
// port and one valid bit per row. A row that is not valid reads as zero, so
// a frame clear only has to reset the valid bits.
// ----------------------------------------------------------------------------
module sxfb_row_store #(
    parameter int unsigned ROWS  = 32,
    parameter int unsigned WIDTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sxfb_pkg::store_ctrl_t     ctrl,
    input  logic [$clog2(ROWS)-1:0]   rd_addr,
    output logic [WIDTH-1:0]          rd_data,
    input  logic [$clog2(ROWS)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]          wr_data
);

    logic [WIDTH-1:0] mem [ROWS];
    logic [ROWS-1:0]  valid_reg;
    logic [ROWS-1:0]  valid_next;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : {WIDTH{1'b0}};

endmodule

@@ rtl/core/sprite_xor_framebuffer.sv @@
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer
// One-bit-per-pixel framebuffer with sprite row XOR drawing, clipping at the
// right and bottom edges, a collision flag, frame clear and row readback.
// ----------------------------------------------------------------------------
// Every request (draw, clear, read) runs through the idle and exec states:
// in the cycle it is accepted the addressed row word is read from the row
// memory, and in the next cycle the row is XORed with the sprite mask,
// written back and the result is loaded into the output register. No new
// request is accepted until the state is back in idle, so the block does not
// take a request while the read-modify-write of the last row word is still
// open. A result held by a stalled output stretches the exec state until
// the output register frees. Clear invalidates all rows at once through
// per-row valid bits, with no clearing pass after reset.
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer #(
    parameter int unsigned SCREEN_WIDTH  = 64,
    parameter int unsigned SCREEN_HEIGHT = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sxfb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sxfb_pkg::rsp_t rsp
);

    localparam int unsigned ADDR_W = $clog2(SCREEN_HEIGHT);
    localparam int unsigned SPAN_W = SCREEN_WIDTH + sxfb_pkg::SPRITE_W;

    sxfb_pkg::state_t      state_reg;
    sxfb_pkg::state_t      state_next;
    sxfb_pkg::req_t        req_reg;
    logic [ADDR_W-1:0]     row_reg;
    logic                  in_range_reg;
    logic [sxfb_pkg::XPOS_W-1:0] col_reg;
    logic                  collision_reg;
    logic                  collision_next;
    sxfb_pkg::rsp_t        rsp_reg;
    sxfb_pkg::rsp_t        rsp_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    logic                  accept;
    logic                  fire;
    logic [sxfb_pkg::XPOS_W-1:0]    col_mod;
    logic [sxfb_pkg::YPOS_W-1:0]    y_mod;
    logic [sxfb_pkg::ROW_SUM_W-1:0] row_sum;
    logic [sxfb_pkg::ROW_SUM_W-1:0] addr_full;
    logic                  addr_in_range;
    logic [sxfb_pkg::SPRITE_W-1:0]  sprite_rev;
    logic [SPAN_W-1:0]     span;
    logic [SCREEN_WIDTH-1:0] mask;
    logic [SCREEN_WIDTH-1:0] rd_data;
    logic                  hit;
    sxfb_pkg::store_ctrl_t store_ctrl;

    assign accept = req_valid && !req_stall;

    // Origin column and row wrap onto the screen; at most seven and three
    // subtractions since the widths are at least eight.
    always_comb
    begin
        col_mod = req.x_pos;
        for (int i = 0; i < 7; i++)
        begin
            if (col_mod >= SCREEN_WIDTH)
            begin
                col_mod = col_mod - sxfb_pkg::XPOS_W'(SCREEN_WIDTH);
            end
        end
        y_mod = req.y_pos;
        for (int i = 0; i < 3; i++)
        begin
            if (y_mod >= SCREEN_HEIGHT)
            begin
                y_mod = y_mod - sxfb_pkg::YPOS_W'(SCREEN_HEIGHT);
            end
        end
    end

    always_comb
    begin
        row_sum = sxfb_pkg::ROW_SUM_W'(y_mod) + sxfb_pkg::ROW_SUM_W'(req.row_offset);
        if (req.operation == sxfb_pkg::OP_DRAW)
        begin
            addr_full = row_sum;
        end
        else
        begin
            addr_full = sxfb_pkg::ROW_SUM_W'(req.y_pos);
        end
        addr_in_range = (addr_full < SCREEN_HEIGHT);
    end

    // Reverse the sprite so its leftmost pixel lands on the origin column;
    // the shift drops pixels past the right edge.
    always_comb
    begin
        for (int k = 0; k < sxfb_pkg::SPRITE_W; k++)
        begin
            sprite_rev[k] = req_reg.sprite_row[sxfb_pkg::SPRITE_W-1-k];
        end
        span = SPAN_W'(sprite_rev) << col_reg;
        mask = span[SCREEN_WIDTH-1:0];
    end

    assign hit = in_range_reg && ((rd_data & mask) != '0);

    sxfb_row_store #(
        .ROWS  (SCREEN_HEIGHT),
        .WIDTH (SCREEN_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .rd_addr (addr_full[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr_addr (row_reg),
        .wr_data (rd_data ^ mask)
    );

    always_comb
    begin
        state_next     = state_reg;
        collision_next = collision_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        fire           = 1'b0;
        store_ctrl     = '0;
        store_ctrl.rd_en = accept;
        req_stall      = (state_reg != sxfb_pkg::S_IDLE);

        case (state_reg)
            sxfb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sxfb_pkg::S_EXEC;
                end
            end
            sxfb_pkg::S_EXEC:
            begin
                // hold until the output register can take the result
                fire = !rsp_valid_reg || !rsp_stall;
                if (fire)
                begin
                    state_next           = sxfb_pkg::S_IDLE;
                    rsp_valid_next       = 1'b1;
                    rsp_next.sprite_done = 1'b0;
                    rsp_next.row_pixels  = '0;
                    case (req_reg.operation)
                        sxfb_pkg::OP_DRAW:
                        begin
                            collision_next = ((req_reg.row_offset == '0) ? 1'b0
                                                                         : collision_reg) | hit;
                            store_ctrl.wr_en     = in_range_reg;
                            rsp_next.sprite_done = req_reg.last_row;
                        end
                        sxfb_pkg::OP_CLEAR:
                        begin
                            store_ctrl.clr       = 1'b1;
                            rsp_next.sprite_done = 1'b1;
                        end
                        sxfb_pkg::OP_READ:
                        begin
                            rsp_next.sprite_done = 1'b1;
                            if (in_range_reg)
                            begin
                                rsp_next.row_pixels = sxfb_pkg::PIXELS_W'(rd_data);
                            end
                        end
                        default:
                        begin
                            rsp_next.sprite_done = 1'b0;
                        end
                    endcase
                    rsp_next.collision = collision_next;
                end
            end
            default:
            begin
                state_next = sxfb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sxfb_pkg::S_IDLE;
            collision_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            collision_reg <= collision_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req;
            row_reg      <= addr_full[ADDR_W-1:0];
            in_range_reg <= addr_in_range;
            col_reg      <= col_mod;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/sxfb_checker.sv @@
// ----------------------------------------------------------------------------
// sxfb_checker
// Port-level checks for the sprite XOR framebuffer, bound to the top level.
// ----------------------------------------------------------------------------
module sxfb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input sxfb_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sxfb_pkg::rsp_t rsp
);

    // one request at a time: stall right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another is in flight");

    // a new result only follows an accepted request
    a_rsp_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
        else $error("result without a request");

    // with a free output the result is registered straight out of the exec state
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !rsp_valid) |-> ##2 rsp_valid)
        else $error("result late");

    // only a read returns pixels
    a_pixels_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !rsp_valid && req.operation != sxfb_pkg::OP_READ)
        |-> ##2 (rsp.row_pixels == '0))
        else $error("pixels returned for a non-read request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule

bind sprite_xor_framebuffer sxfb_checker u_sxfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

@@ tb/sprite_xor_framebuffer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_tb
// Self-checking bench for the sprite XOR framebuffer. A behavioral frame
// model predicts every result (collision, done flag, readback row) when a
// request is accepted. A monitor compares each accepted result in order.
// Directed requests come first: edges, clipping, collision start and clear,
// and the unused code. A long output hold follows, then random sprite traffic
// with random gaps on both channels.
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer_tb;

    localparam int SCR_W        = 64;
    localparam int SCR_H        = 32;
    localparam logic [sxfb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PAUSE_EVERY  = 150;
    localparam int HOLD_LEN     = 250;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAX_PRINTS   = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    sxfb_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sxfb_pkg::rsp_t rsp;

    // frame model
    logic [SCR_W-1:0] frame_model [SCR_H];
    logic             collide_model;
    sxfb_pkg::rsp_t   pending_rsp [$];

    int errors = 0;
    int cycle_count = 0;
    int n_draw = 0, n_clear = 0, n_read = 0, n_unused = 0, n_checked = 0;

    // idling controls, written only by the test thread
    bit req_gaps = 1'b0;
    bit rsp_gaps = 1'b0;
    int hold_ticket = 0;

    // owned by the stall process
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;

    sprite_xor_framebuffer #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp.size());
            $display("[sprite_xor_framebuffer] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch @%0d: %s", cycle_count, msg);
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 10);
        return $urandom_range(12, 40);
    endfunction

    function automatic sxfb_pkg::req_t rand_req();
        logic [31:0] v;
        v = $urandom;
        return sxfb_pkg::req_t'(v[$bits(sxfb_pkg::req_t)-1:0]);
    endfunction

    // Apply one request to the frame model and return its result.
    function automatic sxfb_pkg::rsp_t frame_apply(input sxfb_pkg::req_t r);
        sxfb_pkg::rsp_t   o;
        int               col0;
        int               row;
        int               col;
        logic [SCR_W-1:0] mask;
        o = '0;
        case (r.operation)
            sxfb_pkg::OP_DRAW:
            begin
                col0 = int'(r.x_pos) % SCR_W;
                row  = (int'(r.y_pos) % SCR_H) + int'(r.row_offset);
                if (r.row_offset == '0)
                    collide_model = 1'b0;
                if (row < SCR_H)
                begin
                    mask = '0;
                    for (int k = 0; k < 8; k++)
                    begin
                        col = col0 + k;
                        if (r.sprite_row[7-k] && col < SCR_W)
                            mask[col] = 1'b1;
                    end
                    if ((frame_model[row] & mask) != '0)
                        collide_model = 1'b1;
                    frame_model[row] = frame_model[row] ^ mask;
                end
                o.sprite_done = r.last_row;
            end
            sxfb_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < SCR_H; i++)
                    frame_model[i] = '0;
                o.sprite_done = 1'b1;
            end
            sxfb_pkg::OP_READ:
            begin
                if (int'(r.y_pos) < SCR_H)
                    o.row_pixels = frame_model[r.y_pos];
                o.sprite_done = 1'b1;
            end
            default: ;
        endcase
        o.collision = collide_model;
        return o;
    endfunction

    function automatic sxfb_pkg::req_t mk_req(input logic [sxfb_pkg::OP_W-1:0] op,
                                              input int x, input int y,
                                              input int off, input int bits,
                                              input bit last);
        sxfb_pkg::req_t r;
        r.operation  = op;
        r.x_pos      = x[sxfb_pkg::XPOS_W-1:0];
        r.y_pos      = y[sxfb_pkg::YPOS_W-1:0];
        r.row_offset = off[sxfb_pkg::OFFSET_W-1:0];
        r.sprite_row = bits[sxfb_pkg::SPRITE_W-1:0];
        r.last_row   = last;
        return r;
    endfunction

    // Offer one request; predict its result at the accepting edge.
    task automatic send_req(input sxfb_pkg::req_t r);
        int gap;
        gap = 0;
        if (req_gaps && $urandom_range(0, 99) >= 55)
            gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            req       <= rand_req();
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp.push_back(frame_apply(r));
        case (r.operation)
            sxfb_pkg::OP_DRAW:  n_draw++;
            sxfb_pkg::OP_CLEAR: n_clear++;
            sxfb_pkg::OP_READ:  n_read++;
            default:            n_unused++;
        endcase
    endtask

    // Drop valid and wait until every predicted result has been seen.
    task automatic wait_for_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Output stall: long hold on request, otherwise random bursts.
    always @(negedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served = hold_ticket;
            hold_left   = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (rsp_gaps && $urandom_range(0, 99) < 30)
        begin
            stall_left = idle_len() - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        sxfb_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch($sformatf("unexpected result %h", rsp));
            else
            begin
                want = pending_rsp.pop_front();
                n_checked++;
                if (rsp.collision !== want.collision)
                    report_mismatch($sformatf("collision got %b want %b",
                                              rsp.collision, want.collision));
                if (rsp.sprite_done !== want.sprite_done)
                    report_mismatch($sformatf("sprite_done got %b want %b",
                                              rsp.sprite_done, want.sprite_done));
                if (rsp.row_pixels !== want.row_pixels)
                    report_mismatch($sformatf("row_pixels got %h want %h",
                                              rsp.row_pixels, want.row_pixels));
            end
        end
    end

    task automatic test_directed();
        req_gaps = 1'b0;
        rsp_gaps = 1'b0;
        send_req(mk_req(sxfb_pkg::OP_READ, 0, 0, 0, 0, 0));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 0, 0, 0, 8'hFF, 0));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 0, 0, 1, 8'h81, 1));
        send_req(mk_req(sxfb_pkg::OP_READ, 63, 0, 15, 8'hFF, 1));
        send_req(mk_req(sxfb_pkg::OP_READ, 0, 1, 0, 0, 0));
        // right edge clips, no wrap onto column 0
        send_req(mk_req(sxfb_pkg::OP_DRAW, 60, 0, 0, 8'hFF, 1));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 63, 2, 0, 8'hFF, 1));
        send_req(mk_req(sxfb_pkg::OP_READ, 0, 0, 0, 0, 0));
        send_req(mk_req(sxfb_pkg::OP_READ, 0, 2, 0, 0, 0));
        // erase lit pixels, then keep the flag on later rows
        send_req(mk_req(sxfb_pkg::OP_DRAW, 0, 0, 0, 8'hF0, 0));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 20, 5, 1, 8'h0F, 0));
        // bottom edge clips but still answers
        send_req(mk_req(sxfb_pkg::OP_DRAW, 10, 31, 15, 8'hFF, 1));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 10, 20, 12, 8'hAA, 1));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 63, 31, 0, 8'h80, 1));
        send_req(mk_req(sxfb_pkg::OP_READ, 0, 31, 0, 0, 0));
        // new sprite start resets the flag
        send_req(mk_req(sxfb_pkg::OP_DRAW, 63, 31, 0, 8'h80, 0));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 40, 16, 15, 8'h55, 1));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 0, 1, 0, 8'h81, 0));
        // clear keeps the collision flag
        send_req(mk_req(sxfb_pkg::OP_CLEAR, 63, 31, 15, 8'hFF, 1));
        send_req(mk_req(sxfb_pkg::OP_READ, 0, 1, 0, 0, 0));
        send_req(mk_req(OP_UNUSED, 63, 31, 15, 8'hFF, 1));
        send_req(mk_req(sxfb_pkg::OP_DRAW, 31, 17, 0, 8'h00, 1));
        send_req(mk_req(OP_UNUSED, 0, 0, 0, 0, 0));
        send_req(mk_req(sxfb_pkg::OP_READ, 0, 16, 0, 0, 0));
        wait_for_results();
    endtask

    // Hold the output while requests keep coming so the block backs up.
    task automatic test_output_hold();
        req_gaps = 1'b0;
        rsp_gaps = 1'b0;
        hold_ticket++;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 4 == 3)
                send_req(mk_req(sxfb_pkg::OP_READ, 0, $urandom_range(0, 31), 0, 0, 0));
            else
                send_req(mk_req(sxfb_pkg::OP_DRAW, $urandom_range(0, 63),
                                $urandom_range(0, 31), i % 4,
                                $urandom_range(0, 255), i % 4 == 2));
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int             start_count;
        int             last_pause;
        int             pick;
        int             rows;
        int             x;
        int             y;
        sxfb_pkg::req_t r;
        start_count = n_draw + n_clear + n_read + n_unused;
        last_pause  = start_count;
        req_gaps    = 1'b1;
        rsp_gaps    = 1'b1;
        while (n_draw + n_clear + n_read + n_unused - start_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                x    = $urandom_range(0, 63);
                y    = $urandom_range(0, 31);
                rows = $urandom_range(1, 16);
                for (int k = 0; k < rows; k++)
                    send_req(mk_req(sxfb_pkg::OP_DRAW, x, y, k, $urandom_range(0, 255),
                                    k == rows - 1));
            end
            else if (pick < 86)
            begin
                r = rand_req();
                r.operation = sxfb_pkg::OP_READ;
                send_req(r);
            end
            else if (pick < 88)
            begin
                r = rand_req();
                r.operation = sxfb_pkg::OP_CLEAR;
                send_req(r);
            end
            else if (pick < 91)
            begin
                r = rand_req();
                r.operation = OP_UNUSED;
                send_req(r);
            end
            else
            begin
                // broken sprite: random offset and last flag
                r = rand_req();
                r.operation = sxfb_pkg::OP_DRAW;
                send_req(r);
            end
            if (n_draw + n_clear + n_read + n_unused - last_pause >= PAUSE_EVERY)
            begin
                wait_for_results();
                last_pause = n_draw + n_clear + n_read + n_unused;
                req_gaps   = $urandom_range(0, 3) != 0;
                rsp_gaps   = $urandom_range(0, 3) != 0;
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        for (int i = 0; i < SCR_H; i++)
            frame_model[i] = '0;
        collide_model = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_output_hold();
        test_random_traffic();

        if (pending_rsp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));
        $display("requests: %0d draw, %0d clear, %0d read, %0d unused code",
                 n_draw, n_clear, n_read, n_unused);
        $display("%0d results checked over %0d cycles, %0d mismatches",
                 n_checked, cycle_count, errors);
        if (errors == 0)
            $display("[sprite_xor_framebuffer] OK");
        else
            $display("[sprite_xor_framebuffer] ERROR");
        $finish;
    end

endmodule
